/* sv/nearest_centroid_assign_defines.svh */
// ----------------------------------------------------------------------------
// nearest_centroid_assign_defines
// Assertion macros shared by the nearest-centroid block. Each macro expects
// clk and rst_n in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef NEAREST_CENTROID_ASSIGN_DEFINES_SVH
`define NEAREST_CENTROID_ASSIGN_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define NCA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define NCA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/nca_pkg.sv */
// ----------------------------------------------------------------------------
// nca_pkg
// Fixed field widths, codes and the control state type of the
// nearest-centroid assignment block.
// ----------------------------------------------------------------------------
package nca_pkg;

  // Fixed field widths
  localparam int SLOT_W    = 3;
  localparam int FIDX_W    = 6;
  localparam int CIDX_W    = 3;
  localparam int CLU_W     = 4;
  localparam int FEAT_W    = 7;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 7;
  localparam int DIST_W    = 48;

  // Saturation value of distances
  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  // Widest difference magnitude, in bits, that is still squared exactly
  localparam int SQ_IN_W = 24;

  // Reset values of the configuration registers
  localparam logic [CLU_W-1:0]  CLU_RESET  = 4'd6;
  localparam logic [FEAT_W-1:0] FEAT_RESET = 7'd64;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CLUSTERS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FEATURES = 2'd1;

  // Item commands
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_POINT = 1'b1;

  // Control sequencer
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_FINISH
  } nca_state_t;

endpackage

/* sv/nearest_centroid_assign.sv */
// Nearest-centroid assignment (k-means assignment step, squared Euclidean
// distance). A load item writes one centroid feature into the centroid
// memory. A point item updates all MAX_CLUSTERS running distance sums held
// in a small sums memory: one centroid per cycle goes through a read /
// square / accumulate / write-back pipeline around a single multiplier. A
// point feature occupies the block until its sums are written back, and
// the point's last feature also delivers the nearest centroid index and
// its saturating squared distance (ties go to the lower index). A
// finished result waits in the output register while the next item is
// taken. Configuration writes are always ready and are meant to be made
// while the block is idle.
// ----------------------------------------------------------------------------
// nearest_centroid_assign
// Top level: sequencer, centroid and sums memories, distance pipeline and
// running minimum.
// ----------------------------------------------------------------------------
`include "nearest_centroid_assign_defines.svh"

module nearest_centroid_assign
  import nca_pkg::*;
#(
  parameter int MAX_CLUSTERS = 8,
  parameter int MAX_FEATURES = 64,
  parameter int FEATURE_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // Input item channel
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_command,
  input  logic [SLOT_W-1:0]       in_centroid_slot,
  input  logic [FIDX_W-1:0]       in_feature_index,
  input  logic [FEATURE_BITS-1:0] in_feature_value,
  // Result item channel
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [CIDX_W-1:0]       out_cluster_index,
  output logic [DIST_W-1:0]       out_squared_distance,
  // Configuration write channel
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DAT_W-1:0]    cfg_data
);

  localparam int STORE_DEPTH = MAX_CLUSTERS * MAX_FEATURES;
  localparam int CA_W  = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int CI_W  = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
  localparam int AD_W  = FEATURE_BITS + 1;
  localparam int MUL_W = (AD_W > SQ_IN_W) ? SQ_IN_W : AD_W;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [CLU_W-1:0]  clusters_r;
  logic [FEAT_W-1:0] features_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clusters_r <= CLU_RESET;
      features_r <= FEAT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_CLUSTERS: clusters_r <= cfg_data[CLU_W-1:0];
        CFG_FEATURES: features_r <= cfg_data[FEAT_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp feature count to 1..MAX_FEATURES
  logic [31:0] nf_eff;
  always_comb begin
    if (features_r == '0) begin
      nf_eff = 32'd1;
    end else if (32'(features_r) > 32'(MAX_FEATURES)) begin
      nf_eff = 32'(MAX_FEATURES);
    end else begin
      nf_eff = 32'(features_r);
    end
  end

  // --------------------------------------------------------------------------
  // Input decode
  // --------------------------------------------------------------------------
  nca_state_t state_r, state_nxt;
  logic       in_take;
  logic       ld_go;
  logic       pt_go;

  assign in_take = in_valid && !in_stall;
  assign ld_go   = in_take && (in_command == CMD_LOAD)
                   && (32'(in_centroid_slot) < 32'(MAX_CLUSTERS))
                   && (32'(in_feature_index) < 32'(MAX_FEATURES));
  assign pt_go   = in_take && (in_command == CMD_POINT)
                   && (32'(in_feature_index) < nf_eff);

  // --------------------------------------------------------------------------
  // Item registers for the point feature at work
  // --------------------------------------------------------------------------
  logic [FEATURE_BITS-1:0] x_r;
  logic [FIDX_W-1:0]       fidx_r;
  logic                    last_r;
  logic                    clear_r;
  logic                    sums_live_r;

  always_ff @(posedge clk) begin
    if (pt_go) begin
      x_r     <= in_feature_value;
      fidx_r  <= in_feature_index;
      last_r  <= (32'(in_feature_index) == nf_eff - 32'd1);
      clear_r <= (in_feature_index == '0) || !sums_live_r;
    end
  end

  // Sums memory holds stale data until the first point feature is processed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sums_live_r <= 1'b0;
    end else if (pt_go) begin
      sums_live_r <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  logic [CI_W-1:0] cnt_r, cnt_nxt;
  logic            issue;
  logic            out_load;
  logic            pipe_busy;
  logic            v1_r, v2_r, v3_r, v4_r;
  logic            out_valid_r;

  assign pipe_busy = v1_r || v2_r || v3_r || v4_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (pt_go) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (cnt_r == CI_W'(MAX_CLUSTERS - 1)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!pipe_busy) begin
          state_nxt = last_r ? ST_FINISH : ST_IDLE;
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_stall = 1'b1;
    issue    = 1'b0;
    out_load = 1'b0;
    case (state_r)
      ST_IDLE:   in_stall = 1'b0;
      ST_RUN:    issue    = 1'b1;
      ST_DRAIN:  ;
      ST_FINISH: out_load = !out_valid_r || !out_stall;
      default:   ;
    endcase
  end

  // Lane counter
  always_comb begin
    cnt_nxt = cnt_r;
    if (pt_go) begin
      cnt_nxt = '0;
    end else if (issue) begin
      cnt_nxt = cnt_r + CI_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Centroid memory
  // --------------------------------------------------------------------------
  logic [31:0]             cent_waddr_full;
  logic [31:0]             cent_raddr_full;
  logic [FEATURE_BITS-1:0] cent_rdata;

  assign cent_waddr_full = 32'(in_centroid_slot) * 32'(MAX_FEATURES)
                           + 32'(in_feature_index);
  assign cent_raddr_full = 32'(cnt_r) * 32'(MAX_FEATURES) + 32'(fidx_r);

  nca_ram #(
    .WIDTH (FEATURE_BITS),
    .DEPTH (STORE_DEPTH)
  ) u_cent_ram (
    .clk   (clk),
    .we    (ld_go),
    .waddr (cent_waddr_full[CA_W-1:0]),
    .wdata (in_feature_value),
    .re    (issue),
    .raddr (cent_raddr_full[CA_W-1:0]),
    .rdata (cent_rdata)
  );

  // --------------------------------------------------------------------------
  // Sums memory (read-modify-write, one lane per cycle)
  // --------------------------------------------------------------------------
  logic [DIST_W-1:0] sum_rdata;
  logic [DIST_W-1:0] sum3;
  logic [CI_W-1:0]   lane3_r;

  nca_ram #(
    .WIDTH (DIST_W),
    .DEPTH (MAX_CLUSTERS)
  ) u_sum_ram (
    .clk   (clk),
    .we    (v3_r),
    .waddr (lane3_r),
    .wdata (sum3),
    .re    (issue),
    .raddr (cnt_r),
    .rdata (sum_rdata)
  );

  // --------------------------------------------------------------------------
  // Stage 1: memory data out, absolute difference
  // --------------------------------------------------------------------------
  logic [CI_W-1:0]   lane1_r, lane2_r, lane4_r;
  logic signed [AD_W-1:0] diff1;
  logic [AD_W-1:0]   ad1;
  logic [AD_W-1:0]   ad2_r;
  logic              big2_r;
  logic [DIST_W-1:0] old2_r;

  assign diff1 = $signed({x_r[FEATURE_BITS-1], x_r})
               - $signed({cent_rdata[FEATURE_BITS-1], cent_rdata});
  assign ad1   = diff1[AD_W-1] ? AD_W'(-diff1) : AD_W'(diff1);

  always_ff @(posedge clk) begin
    lane1_r <= cnt_r;
    ad2_r   <= ad1;
    big2_r  <= (ad1 >> SQ_IN_W) != '0;
    old2_r  <= clear_r ? '0 : sum_rdata;
    lane2_r <= lane1_r;
  end

  // --------------------------------------------------------------------------
  // Stage 2: square, saturate wide differences
  // --------------------------------------------------------------------------
  logic [2*MUL_W-1:0] prod2;
  logic [DIST_W-1:0]  sq3_r;
  logic [DIST_W-1:0]  old3_r;

  assign prod2 = ad2_r[MUL_W-1:0] * ad2_r[MUL_W-1:0];

  always_ff @(posedge clk) begin
    sq3_r   <= big2_r ? DIST_MAX : DIST_W'(prod2);
    old3_r  <= old2_r;
    lane3_r <= lane2_r;
  end

  // --------------------------------------------------------------------------
  // Stage 3: saturating accumulate, write back
  // --------------------------------------------------------------------------
  logic [DIST_W:0]   add3;
  logic [DIST_W-1:0] sum4_r;

  assign add3 = {1'b0, old3_r} + {1'b0, sq3_r};
  assign sum3 = add3[DIST_W] ? DIST_MAX : add3[DIST_W-1:0];

  always_ff @(posedge clk) begin
    sum4_r  <= sum3;
    lane4_r <= lane3_r;
  end

  // Stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: running strict minimum over the centroids in use
  // --------------------------------------------------------------------------
  logic              lane4_first;
  logic              lane4_used;
  logic              best_upd;
  logic [DIST_W-1:0] best_r;
  logic [CI_W-1:0]   best_idx_r;

  assign lane4_first = (lane4_r == '0);
  assign lane4_used  = lane4_first || (32'(lane4_r) < 32'(clusters_r));
  assign best_upd    = v4_r && lane4_used && (lane4_first || (sum4_r < best_r));

  always_ff @(posedge clk) begin
    if (best_upd) begin
      best_r     <= sum4_r;
      best_idx_r <= lane4_r;
    end
  end

  // --------------------------------------------------------------------------
  // Output register: hold the result until taken
  // --------------------------------------------------------------------------
  logic [CIDX_W-1:0] out_idx_r;
  logic [DIST_W-1:0] out_dist_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_idx_r  <= CIDX_W'(best_idx_r);
      out_dist_r <= best_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_cluster_index    = out_idx_r;
  assign out_squared_distance = out_dist_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `NCA_ASSERT_NOW(a_load_only_idle, ld_go, state_r == ST_IDLE,
                  "centroid write outside idle")
  `NCA_ASSERT_NOW(a_finish_drained, state_r == ST_FINISH, !pipe_busy,
                  "result loaded before the sums pipeline drained")
  `NCA_ASSERT_NOW(a_sum_wr_in_item, v3_r,
                  state_r == ST_RUN || state_r == ST_DRAIN,
                  "sums write outside point processing")
  `NCA_ASSERT_NEXT(a_first_lane_seeds, v4_r && lane4_first, best_idx_r == '0,
                   "minimum not seeded by centroid zero")
  `NCA_ASSERT_NEXT(a_run_fills_pipe, state_r == ST_RUN, v1_r,
                   "lane read issued without stage valid")

endmodule

/* sv/nca_ram.sv */
// ----------------------------------------------------------------------------
// nca_ram
// Generic single-write, single-read synchronous RAM with a registered
// read port.
// ----------------------------------------------------------------------------
module nca_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
